// ----- hw/rtl/owm_pkg.sv -----
// Package for the 1-Wire bus master: request codes, sequencer phases,
// configuration register indexes and the structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package owm_pkg;

	localparam int BYTE_BITS = 8;
	localparam int BIT_IDX_W = $clog2(BYTE_BITS);
	localparam int USEC_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 10;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_RESET = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_RST_REC  = 4'd3,
		PH_SLOT     = 4'd4
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RESET_LOW       = 3'd0,
		CFG_PRESENCE_SAMPLE = 3'd1,
		CFG_RESET_RECOVER   = 3'd2,
		CFG_WRITE_ONE_LOW   = 3'd3,
		CFG_WRITE_ZERO_LOW  = 3'd4,
		CFG_READ_SAMPLE     = 3'd5,
		CFG_SLOT            = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [9:0] reset_low_us;
		logic [7:0] presence_sample_us;
		logic [9:0] reset_recover_us;
		logic [5:0] write_one_low_us;
		logic [6:0] write_zero_low_us;
		logic [5:0] read_sample_us;
		logic [7:0] slot_us;
	} cfg_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] read_data;
		logic       rejected;
	} result_t;

endpackage

// ----- hw/rtl/owm_in_if.sv -----
// Input channel of the 1-Wire bus master: valid/ready handshake and payload.
// Depends on nothing but the standard types.
`timescale 1ns / 1ps

interface owm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] data_byte;
	logic       line_level;

	modport source (output valid, output req_type, output data_byte, output line_level,
		input ready);
	modport sink (input valid, input req_type, input data_byte, input line_level,
		output ready);
endinterface

// ----- hw/rtl/owm_out_if.sv -----
// Result channel of the 1-Wire bus master: valid/ready handshake and payload.
// Depends on nothing but the standard types.
`timescale 1ns / 1ps

interface owm_out_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic       presence;
	logic [7:0] read_data;
	logic       rejected;

	modport source (output valid, output drive_low, output busy_res, output done_res,
		output presence, output read_data, output rejected, input ready);
	modport sink (input valid, input drive_low, input busy_res, input done_res,
		input presence, input read_data, input rejected, output ready);
endinterface

// ----- hw/rtl/one_wire_bus_master.sv -----
// Top level of the standard-speed 1-Wire bus master: channels, input and
// result registers, configuration registers. Uses owm_pkg, owm_in_if,
// owm_out_if and owm_core.
//
// Usage. Each item on in_ch is either a one-microsecond tick carrying the
// sampled bus level, or a command (bus reset with presence detect, write a
// byte, read a byte). Every item yields exactly one item on out_ch with the
// bus drive, busy, done, presence, last read byte and a rejected flag for a
// command that arrived while an operation was still running.
// Path: an item is captured in the input register at the edge it is
// accepted and its result is then loaded into the result register, where
// it raises out_ch.valid.
// Throughput: one item per cycle while out_ch.ready is high; the sequencer
// state is a single step of short logic between the input and result registers.
// Stalls: when out_ch.ready is low the result register holds its item and
// the input register may still take one further item, after which
// in_ch.ready falls until the result is taken.
// Reset: arst_n clears both pipeline valids, puts the sequencer in idle and
// loads the configuration registers with standard-speed timings. Timing
// registers are written through cfg_wr_en, cfg_index and cfg_data while idle.
`timescale 1ns / 1ps

module one_wire_bus_master (
	input  logic                            clk,
	input  logic                            arst_n,
	owm_in_if.sink                          in_ch,
	owm_out_if.source                       out_ch,
	input  logic                            cfg_wr_en,
	input  logic [owm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [owm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// Input register stage.
	logic             valid_s1;
	owm_pkg::req_t    req_s1;
	logic [7:0]       data_s1;
	logic             level_s1;

	// Result register.
	logic             out_valid_q;
	owm_pkg::result_t out_q;

	owm_pkg::cfg_t    cfg_q;
	owm_pkg::result_t res;
	logic             advance;

	// The input stage moves on whenever the result register is free or is
	// being emptied in this cycle.
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			req_s1   <= owm_pkg::req_t'(in_ch.req_type);
			data_s1  <= in_ch.data_byte;
			level_s1 <= in_ch.line_level;
		end
	end

	// Configuration registers, to be written only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_us       <= 10'd480;
			cfg_q.presence_sample_us <= 8'd70;
			cfg_q.reset_recover_us   <= 10'd410;
			cfg_q.write_one_low_us   <= 6'd6;
			cfg_q.write_zero_low_us  <= 7'd60;
			cfg_q.read_sample_us     <= 6'd15;
			cfg_q.slot_us            <= 8'd70;
		end else if (cfg_wr_en) begin
			unique case (owm_pkg::cfg_idx_t'(cfg_index))
				owm_pkg::CFG_RESET_LOW:       cfg_q.reset_low_us       <= cfg_data;
				owm_pkg::CFG_PRESENCE_SAMPLE: cfg_q.presence_sample_us <= cfg_data[7:0];
				owm_pkg::CFG_RESET_RECOVER:   cfg_q.reset_recover_us   <= cfg_data;
				owm_pkg::CFG_WRITE_ONE_LOW:   cfg_q.write_one_low_us   <= cfg_data[5:0];
				owm_pkg::CFG_WRITE_ZERO_LOW:  cfg_q.write_zero_low_us  <= cfg_data[6:0];
				owm_pkg::CFG_READ_SAMPLE:     cfg_q.read_sample_us     <= cfg_data[5:0];
				owm_pkg::CFG_SLOT:            cfg_q.slot_us            <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// The sequencer state steps exactly when an item passes to the result
	// register, so each item is applied once.
	owm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.data   (data_s1),
		.level  (level_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= res;
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.drive_low = out_q.drive_low;
	assign out_ch.busy_res  = out_q.busy_res;
	assign out_ch.done_res  = out_q.done_res;
	assign out_ch.presence  = out_q.presence;
	assign out_ch.read_data = out_q.read_data;
	assign out_ch.rejected  = out_q.rejected;

endmodule

// ----- hw/rtl/owm_core.sv -----
// Timing sequencer of the 1-Wire bus master: phase, microsecond counter,
// bit counter and shift register, stepped once per item. Uses owm_pkg.
`timescale 1ns / 1ps

module owm_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  owm_pkg::req_t                 req,
	input  logic [7:0]                    data,
	input  logic                          level,
	input  owm_pkg::cfg_t                 cfg,
	output owm_pkg::result_t              res
);

	owm_pkg::phase_t                       phase_q, phase_d;
	logic [owm_pkg::USEC_W-1:0]            usec_q, usec_d, usec_inc;
	logic [owm_pkg::BIT_IDX_W-1:0]         bit_q, bit_d;
	logic [7:0]                            shift_q, shift_d;
	owm_pkg::req_t                         op_q, op_d;
	logic                                  pres_q, pres_d;
	logic [7:0]                            rbyte_q, rbyte_d;
	logic                                  done, rejected;
	logic [7:0]                            sample_at;
	logic [6:0]                            low_time;

	assign usec_inc = usec_q + 1'b1;
	// A read sample placed beyond the slot end happens on the slot's last tick.
	assign sample_at = ({2'b00, cfg.read_sample_us} < cfg.slot_us) ?
		{2'b00, cfg.read_sample_us} : cfg.slot_us;

	always_comb begin
		phase_d  = phase_q;
		usec_d   = usec_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		op_d     = op_q;
		pres_d   = pres_q;
		rbyte_d  = rbyte_q;
		done     = 1'b0;
		rejected = 1'b0;
		if (req != owm_pkg::REQ_TICK) begin
			if (phase_q != owm_pkg::PH_IDLE) begin
				rejected = 1'b1;
			end else begin
				usec_d  = '0;
				bit_d   = '0;
				op_d    = req;
				shift_d = (req == owm_pkg::REQ_WRITE) ? data : 8'h00;
				phase_d = (req == owm_pkg::REQ_RESET) ? owm_pkg::PH_RST_LOW : owm_pkg::PH_SLOT;
			end
		end else if (phase_q != owm_pkg::PH_IDLE) begin
			usec_d = usec_inc;
			unique case (phase_q)
				owm_pkg::PH_RST_LOW: begin
					if (usec_inc >= cfg.reset_low_us) begin
						phase_d = owm_pkg::PH_RST_WAIT;
						usec_d  = '0;
					end
				end
				owm_pkg::PH_RST_WAIT: begin
					if (usec_inc >= {2'b00, cfg.presence_sample_us}) begin
						pres_d  = ~level;
						phase_d = owm_pkg::PH_RST_REC;
						usec_d  = '0;
					end
				end
				owm_pkg::PH_RST_REC: begin
					if (usec_inc >= cfg.reset_recover_us) begin
						phase_d = owm_pkg::PH_IDLE;
						usec_d  = '0;
						done    = 1'b1;
					end
				end
				owm_pkg::PH_SLOT: begin
					if (op_q == owm_pkg::REQ_READ && usec_inc == {2'b00, sample_at} && level)
						shift_d[bit_q] = 1'b1;
					if (usec_inc >= {2'b00, cfg.slot_us}) begin
						usec_d = '0;
						if (bit_q == owm_pkg::BIT_IDX_W'(owm_pkg::BYTE_BITS - 1)) begin
							bit_d   = '0;
							if (op_q == owm_pkg::REQ_READ)
								rbyte_d = shift_d;
							phase_d = owm_pkg::PH_IDLE;
							done    = 1'b1;
						end else begin
							bit_d = bit_q + 1'b1;
						end
					end
				end
				default: begin
					phase_d = owm_pkg::PH_IDLE;
					usec_d  = '0;
				end
			endcase
		end
	end

	// Drive is judged on the state after this item.
	always_comb begin
		if (op_d == owm_pkg::REQ_WRITE && !shift_d[bit_d])
			low_time = cfg.write_zero_low_us;
		else
			low_time = {1'b0, cfg.write_one_low_us};
	end

	always_comb begin
		res.drive_low = (phase_d == owm_pkg::PH_RST_LOW) ||
			(phase_d == owm_pkg::PH_SLOT && usec_d < {3'b000, low_time} &&
			 usec_d < {2'b00, cfg.slot_us});
		res.busy_res  = (phase_d != owm_pkg::PH_IDLE);
		res.done_res  = done;
		res.presence  = pres_d;
		res.read_data = rbyte_d;
		res.rejected  = rejected;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= owm_pkg::PH_IDLE;
			usec_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			op_q    <= owm_pkg::REQ_TICK;
			pres_q  <= 1'b0;
			rbyte_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			usec_q  <= usec_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			op_q    <= op_d;
			pres_q  <= pres_d;
			rbyte_q <= rbyte_d;
		end
	end

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the standard-speed 1-Wire bus master.
// Needs owm_pkg, owm_in_if, owm_out_if and one_wire_bus_master from the RTL.
// A cycle-free model of the sequencer predicts every result item.
`timescale 1ns / 1ps

module testbench;
	import owm_pkg::*;

	// Timing that the block loads at reset, one value per register.
	localparam cfg_t STANDARD_TIMING = '{
		reset_low_us: 10'd480, presence_sample_us: 8'd70, reset_recover_us: 10'd410,
		write_one_low_us: 6'd6, write_zero_low_us: 7'd60, read_sample_us: 6'd15,
		slot_us: 8'd70};

	// How the bus level is chosen on the ticks of an operation.
	localparam int LEVEL_LOW = 0;
	localparam int LEVEL_HIGH = 1;
	localparam int LEVEL_RANDOM = 2;

	localparam int RANDOM_ITEMS = 200;
	// A result passes through the input and result registers after its item is
	// taken; SETTLE_CYCLES gives margin before the bus is touched again.
	localparam int SETTLE_CYCLES = 6;
	// Time limit for the whole run in ns; the clock period is 12 ns.
	localparam int RUN_LIMIT_NS = 5_000_000;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	owm_in_if in_ch ();
	owm_out_if out_ch ();

	one_wire_bus_master u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predicted state of the sequencer and its timing registers. The state moves
	// only when an item is accepted and the timing only in apply_config; the
	// stimulus consults the state to see whether the master is still busy.
	cfg_t timing;
	phase_t bus_phase;
	logic [USEC_W-1:0] usec_ticks;
	logic [BIT_IDX_W-1:0] bit_pos;
	logic [7:0] shift_reg;
	req_t op_req;
	logic presence_seen;
	logic [7:0] last_read;

	result_t expected_results[$];
	int items_sent;
	int failures;
	// When clear, neither side inserts gaps or stalls.
	bit gaps_on;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Low time of the slot in progress: a zero bit of a written byte uses the
	// zero low time, every other slot uses the one low time.
	function automatic int slot_low_time();
		if (op_req == REQ_WRITE && !shift_reg[bit_pos])
			return int'(timing.write_zero_low_us);
		return int'(timing.write_one_low_us);
	endfunction

	// Advances the predicted sequencer by one item and returns its result.
	function automatic result_t step_master(req_t req, logic [7:0] data, logic level);
		result_t res;
		int sample_at;
		res = '0;
		if (req != REQ_TICK) begin
			// A command only starts when the master is idle; otherwise it is
			// dropped and flagged.
			if (bus_phase != PH_IDLE) begin
				res.rejected = 1'b1;
			end else begin
				usec_ticks = '0;
				bit_pos = '0;
				op_req = req;
				shift_reg = (req == REQ_WRITE) ? data : 8'h00;
				bus_phase = (req == REQ_RESET) ? PH_RST_LOW : PH_SLOT;
			end
		end else if (bus_phase != PH_IDLE) begin
			usec_ticks = usec_ticks + 1'b1;
			case (bus_phase)
				PH_RST_LOW: begin
					if (usec_ticks >= timing.reset_low_us) begin
						bus_phase = PH_RST_WAIT;
						usec_ticks = '0;
					end
				end
				PH_RST_WAIT: begin
					// A device answers by holding the bus low at the sample.
					if (usec_ticks >= timing.presence_sample_us) begin
						presence_seen = ~level;
						bus_phase = PH_RST_REC;
						usec_ticks = '0;
					end
				end
				PH_RST_REC: begin
					if (usec_ticks >= timing.reset_recover_us) begin
						bus_phase = PH_IDLE;
						usec_ticks = '0;
						res.done_res = 1'b1;
					end
				end
				PH_SLOT: begin
					// A sample point beyond the slot end falls on its last tick.
					sample_at = (timing.read_sample_us < timing.slot_us) ?
						int'(timing.read_sample_us) : int'(timing.slot_us);
					if (op_req == REQ_READ && int'(usec_ticks) == sample_at && level)
						shift_reg[bit_pos] = 1'b1;
					if (usec_ticks >= timing.slot_us) begin
						usec_ticks = '0;
						if (int'(bit_pos) + 1 >= BYTE_BITS) begin
							bit_pos = '0;
							if (op_req == REQ_READ)
								last_read = shift_reg;
							bus_phase = PH_IDLE;
							res.done_res = 1'b1;
						end else begin
							bit_pos = bit_pos + 1'b1;
						end
					end
				end
				default: begin
					bus_phase = PH_IDLE;
					usec_ticks = '0;
				end
			endcase
		end
		// The drive follows the state after the item; a low time longer than
		// the slot is cut off at the slot end.
		res.drive_low = (bus_phase == PH_RST_LOW) ||
			(bus_phase == PH_SLOT && int'(usec_ticks) < slot_low_time() &&
			usec_ticks < timing.slot_us);
		res.busy_res = (bus_phase != PH_IDLE);
		res.presence = presence_seen;
		res.read_data = last_read;
		return res;
	endfunction

	function automatic void compare_field(string field, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			failures++;
		end
	endfunction

	// Called at the edge where a result item is taken from the block.
	task automatic check_result();
		result_t want;
		if (expected_results.size() == 0) begin
			$error("result item arrived with none expected");
			failures++;
			return;
		end
		want = expected_results.pop_front();
		compare_field("drive_low", want.drive_low, out_ch.drive_low);
		compare_field("busy_res", want.busy_res, out_ch.busy_res);
		compare_field("done_res", want.done_res, out_ch.done_res);
		compare_field("presence", want.presence, out_ch.presence);
		compare_field("read_data", want.read_data, out_ch.read_data);
		compare_field("rejected", want.rejected, out_ch.rejected);
	endtask

	// Offers one item and waits for the handshake. Valid is left high so that
	// back-to-back items need no extra edge; a gap lowers it first.
	task automatic send_item(req_t req, logic [7:0] data, logic level);
		int gap;
		gap = gaps_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.req_type <= req;
		in_ch.data_byte <= data;
		in_ch.line_level <= level;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		expected_results.push_back(step_master(req, data, level));
		items_sent++;
	endtask

	// Starts one operation and ticks until it completes. With reject_odds
	// above zero, a stray command follows a tick with odds of one in that.
	task automatic run_op(req_t cmd, logic [7:0] data, int level_mode, int reject_odds);
		logic level;
		send_item(cmd, data, 1'($urandom));
		while (bus_phase != PH_IDLE) begin
			level = (level_mode == LEVEL_RANDOM) ? 1'($urandom) : 1'(level_mode);
			send_item(REQ_TICK, 8'($urandom), level);
			if (bus_phase != PH_IDLE && reject_odds > 0 &&
					$urandom_range(1, reject_odds) == 1)
				send_item(req_t'($urandom_range(REQ_RESET, REQ_READ)), 8'($urandom),
					1'($urandom));
		end
	endtask

	// Lets every outstanding result come back, then waits out the settle margin.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all seven timing registers, one per edge, while the master is idle.
	task automatic apply_config(cfg_t cfg);
		cfg_idx_t idx;
		drain();
		idx = idx.first();
		repeat (idx.num()) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx;
			case (idx)
				CFG_RESET_LOW:       cfg_data <= CFG_DATA_W'(cfg.reset_low_us);
				CFG_PRESENCE_SAMPLE: cfg_data <= CFG_DATA_W'(cfg.presence_sample_us);
				CFG_RESET_RECOVER:   cfg_data <= CFG_DATA_W'(cfg.reset_recover_us);
				CFG_WRITE_ONE_LOW:   cfg_data <= CFG_DATA_W'(cfg.write_one_low_us);
				CFG_WRITE_ZERO_LOW:  cfg_data <= CFG_DATA_W'(cfg.write_zero_low_us);
				CFG_READ_SAMPLE:     cfg_data <= CFG_DATA_W'(cfg.read_sample_us);
				default:             cfg_data <= CFG_DATA_W'(cfg.slot_us);
			endcase
			@(posedge clk);
			idx = idx.next();
		end
		cfg_wr_en <= 1'b0;
		timing = cfg;
	endtask

	// Ticks while idle must change nothing, whatever the bus level or byte.
	task automatic test_idle_ticks();
		send_item(REQ_TICK, 8'h00, 1'b0);
		send_item(REQ_TICK, 8'hFF, 1'b1);
		send_item(REQ_TICK, 8'h55, 1'b0);
		send_item(REQ_TICK, 8'hAA, 1'b1);
	endtask

	// Reset-value timing: a write whose zero and one bits use both low times.
	task automatic test_standard_timing();
		run_op(REQ_WRITE, 8'hA5, LEVEL_RANDOM, 0);
	endtask

	// Short timings: every register at one and the slot at two.
	task automatic test_shortest_timing();
		apply_config('{reset_low_us: 10'd1, presence_sample_us: 8'd1,
			reset_recover_us: 10'd1, write_one_low_us: 6'd1, write_zero_low_us: 7'd1,
			read_sample_us: 6'd1, slot_us: 8'd2});
		run_op(REQ_RESET, 8'h00, LEVEL_LOW, 0);
		run_op(REQ_WRITE, 8'h00, LEVEL_RANDOM, 0);
		run_op(REQ_WRITE, 8'hFF, LEVEL_RANDOM, 0);
		run_op(REQ_READ, 8'h00, LEVEL_LOW, 0);
		run_op(REQ_READ, 8'h00, LEVEL_RANDOM, 0);
	endtask

	// With zero lengths each stage ends on its first tick.
	task automatic test_zero_timing();
		apply_config('0);
		run_op(REQ_RESET, 8'h00, LEVEL_RANDOM, 0);
		run_op(REQ_WRITE, 8'h3C, LEVEL_RANDOM, 0);
		run_op(REQ_READ, 8'h00, LEVEL_HIGH, 0);
	endtask

	// Sample point and low times beyond the slot end, then a sample point
	// that coincides with it.
	task automatic test_sample_past_slot();
		apply_config('{reset_low_us: 10'd4, presence_sample_us: 8'd3,
			reset_recover_us: 10'd4, write_one_low_us: 6'd20, write_zero_low_us: 7'd127,
			read_sample_us: 6'd63, slot_us: 8'd10});
		run_op(REQ_READ, 8'h00, LEVEL_RANDOM, 0);
		run_op(REQ_WRITE, 8'hC3, LEVEL_RANDOM, 0);
		apply_config('{reset_low_us: 10'd4, presence_sample_us: 8'd3,
			reset_recover_us: 10'd4, write_one_low_us: 6'd3, write_zero_low_us: 7'd8,
			read_sample_us: 6'd10, slot_us: 8'd10});
		run_op(REQ_READ, 8'h00, LEVEL_RANDOM, 0);
	endtask

	// A command after every tick that leaves the operation busy, so each busy
	// phase sees rejected commands of random kinds.
	task automatic test_busy_commands();
		apply_config('{reset_low_us: 10'd3, presence_sample_us: 8'd3,
			reset_recover_us: 10'd3, write_one_low_us: 6'd2, write_zero_low_us: 7'd4,
			read_sample_us: 6'd3, slot_us: 8'd6});
		run_op(REQ_RESET, 8'h00, LEVEL_RANDOM, 1);
		run_op(REQ_WRITE, 8'h81, LEVEL_RANDOM, 1);
		run_op(REQ_READ, 8'h00, LEVEL_RANDOM, 1);
	endtask

	// Short random timings so that many operations complete; each setting
	// carries a handful of operations with stray ticks and commands mixed in.
	task automatic test_random_traffic();
		cfg_t cfg;
		int stop_at;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			cfg.reset_low_us = $urandom_range(1, 12);
			cfg.presence_sample_us = $urandom_range(1, 8);
			cfg.reset_recover_us = $urandom_range(1, 12);
			cfg.write_one_low_us = $urandom_range(1, 8);
			cfg.write_zero_low_us = $urandom_range(1, 16);
			cfg.read_sample_us = $urandom_range(1, 12);
			cfg.slot_us = $urandom_range(2, 16);
			apply_config(cfg);
			repeat ($urandom_range(3, 8)) begin
				// Runs without gaps or stalls come up about one time in four.
				gaps_on = ($urandom_range(0, 3) != 0);
				repeat ($urandom_range(0, 2))
					send_item(REQ_TICK, 8'($urandom), 1'($urandom));
				run_op(req_t'($urandom_range(REQ_RESET, REQ_READ)), 8'($urandom),
					LEVEL_RANDOM, ($urandom_range(0, 3) == 0) ? 8 : 0);
			end
		end
		gaps_on = 1'b1;
	endtask

	// Result side: with gaps on, ready is dropped for a random number of cycles
	// before some result items, and every accepted result is checked at once.
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = gaps_on ? $urandom_range(0, 3) : 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid)
				@(posedge clk);
			check_result();
		end
	end

	// Main sequence: reset once, then the tests in turn, then the verdict.
	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_RESET_LOW;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.req_type <= REQ_TICK;
		in_ch.data_byte <= 8'h00;
		in_ch.line_level <= 1'b1;

		timing = STANDARD_TIMING;
		bus_phase = PH_IDLE;
		usec_ticks = '0;
		bit_pos = '0;
		shift_reg = 8'h00;
		op_req = REQ_TICK;
		presence_seen = 1'b0;
		last_read = 8'h00;
		items_sent = 0;
		failures = 0;
		gaps_on = 1'b1;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ticks();
		test_standard_timing();
		test_shortest_timing();
		test_zero_timing();
		test_sample_past_slot();
		test_busy_commands();
		test_random_traffic();
		drain();

		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#(RUN_LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- one_wire_bus_master.f -----
hw/rtl/owm_pkg.sv
hw/rtl/owm_in_if.sv
hw/rtl/owm_out_if.sv
hw/rtl/owm_core.sv
hw/rtl/one_wire_bus_master.sv
bench/testbench.sv
